// File: rtl/lfida_pkg.sv
// ----------------------------------------------------------------------------
// lfida_pkg
// Shared types, constants and helper functions for the lowest-free ID
// allocator: pool geometry, register map, command struct and encoders.
// ----------------------------------------------------------------------------
package lfida_pkg;

  // Pool geometry: the free bitmap is kept as rows of ROW_W bits
  localparam int POOL_SIZE = 256;
  localparam int ROW_W     = (POOL_SIZE < 16) ? POOL_SIZE : 16;
  localparam int ROW_BW    = $clog2(ROW_W);
  localparam int ROWS      = POOL_SIZE / ROW_W;
  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Field widths
  localparam int ID_W  = 32;
  localparam int CNT_W = 9;

  // Largest usable count: the pool size, limited by the count field width
  localparam int CNT_LIMIT = (POOL_SIZE < (2 ** CNT_W) - 1) ? POOL_SIZE : (2 ** CNT_W) - 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CNT_LIMIT);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam logic REG_BASE_ID  = 1'b0;
  localparam logic REG_ID_COUNT = 1'b1;

  // Operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } lfida_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // latch the item and issue the row read
    logic commit;  // update the row, counters and result registers
  } lfida_cmd_t;

  // Initial content of one bitmap row: ones below the clipped count
  function automatic logic [ROW_W-1:0] init_row(logic [ROW_AW-1:0] row,
                                                logic [CNT_W-1:0]  n);
    logic [ROW_W-1:0] v;
    v = '0;
    for (int j = 0; j < ROW_W; j++) begin
      v[j] = ((int'(row) * ROW_W + j) < int'(n));
    end
    return v;
  endfunction

  // Initial row summary: a row holds free IDs if its first index is below n
  function automatic logic [ROWS-1:0] init_summary(logic [CNT_W-1:0] n);
    logic [ROWS-1:0] v;
    v = '0;
    for (int r = 0; r < ROWS; r++) begin
      v[r] = ((r * ROW_W) < int'(n));
    end
    return v;
  endfunction

  // Index of the lowest set bit in a row
  function automatic logic [ROW_BW-1:0] lowest_bit(logic [ROW_W-1:0] v);
    logic [ROW_BW-1:0] idx;
    idx = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (v[j]) idx = ROW_BW'(j);
    end
    return idx;
  endfunction

  // Index of the lowest row that holds a free ID
  function automatic logic [ROW_AW-1:0] lowest_row(logic [ROWS-1:0] v);
    logic [ROW_AW-1:0] idx;
    idx = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (v[r]) idx = ROW_AW'(r);
    end
    return idx;
  endfunction

endpackage

// File: rtl/lowest_free_id_allocator_top.sv
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_top
// Lowest-free-first ID allocator with an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries op_i and release_id_i.
//   op_i selects allocate or release. Each item gives exactly one result on
//   the output channel (out_valid_o / out_stall_i): granted_o, given_id_o,
//   released_o and the free count after the item.
//   The accept state searches the row summary (or decodes the released ID)
//   and reads one 16-bit bitmap row from RAM; the execute state then updates
//   that row and loads the result register, waiting while a stalled result
//   still holds it. The block takes no new item until then.
//   The next item is taken while a result still waits in the output
//   register. If the receiver stalls, the result holds and the update of the
//   following item waits until the register frees up.
//   Reset leaves base_id and id_count at zero, so the pool is empty. Writing
//   either register (byte address 0 or 4) refills the pool at once: every ID
//   in range becomes free, with no clearing pass. Write only while idle.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_top
  import lfida_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [ID_W-1:0]   release_id_i,
  // Output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              granted_o,
  output logic [ID_W-1:0]   given_id_o,
  output logic              released_o,
  output logic [CNT_W-1:0]  free_count_o,
  // Register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [ID_W-1:0]  base_id_q;
  logic [CNT_W-1:0] id_count_q;
  logic [CNT_W-1:0] id_count_sel;
  logic [CNT_W-1:0] n_clip;
  logic             cfg_wr;
  lfida_cmd_t       cmd;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q  <= '0;
      id_count_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BASE_ID:  base_id_q  <= pwdata;
        REG_ID_COUNT: id_count_q <= pwdata[CNT_W-1:0];
        default:      base_id_q  <= base_id_q;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      REG_BASE_ID:  prdata = base_id_q;
      REG_ID_COUNT: prdata = 32'(id_count_q);
      default:      prdata = '0;
    endcase
  end

  // Use the incoming count during a count write so the refill sees the new range
  assign id_count_sel = (cfg_wr && (paddr[2] == REG_ID_COUNT)) ? pwdata[CNT_W-1:0]
                                                                : id_count_q;

  // Clip the count to the pool
  assign n_clip = (id_count_sel > CNT_MAX) ? CNT_MAX : id_count_sel;

  lfida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lfida_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_init_i   (cfg_wr),
    .base_id_i    (base_id_q),
    .n_i          (n_clip),
    .op_i         (op_i),
    .release_id_i (release_id_i),
    .granted_o    (granted_o),
    .given_id_o   (given_id_o),
    .released_o   (released_o),
    .free_count_o (free_count_o)
  );

endmodule

// File: rtl/lfida_ram.sv
// ----------------------------------------------------------------------------
// lfida_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfida_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lfida_ctrl.sv
// ----------------------------------------------------------------------------
// lfida_ctrl
// Controller: sequences one item through read and update, and owns the
// valid flag of the result register.
// ----------------------------------------------------------------------------
module lfida_ctrl
  import lfida_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output lfida_cmd_t cmd_o
);

  lfida_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.commit = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Result valid: set on commit, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/lfida_dp.sv
// ----------------------------------------------------------------------------
// lfida_dp
// Datapath: row summary, row valid bits, bitmap RAM, free counter and the
// result register. Searches the summary, then the selected row.
// ----------------------------------------------------------------------------
module lfida_dp
  import lfida_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lfida_cmd_t       cmd_i,
  input  logic             cfg_init_i,
  input  logic [ID_W-1:0]  base_id_i,
  input  logic [CNT_W-1:0] n_i,
  input  logic             op_i,
  input  logic [ID_W-1:0]  release_id_i,
  output logic             granted_o,
  output logic [ID_W-1:0]  given_id_o,
  output logic             released_o,
  output logic [CNT_W-1:0] free_count_o
);

  // Control state
  logic [ROWS-1:0]  summary_q, summary_d;
  logic [ROWS-1:0]  row_valid_q, row_valid_d;
  logic [CNT_W-1:0] free_total_q, free_total_d;

  // Item registers
  logic              op_q;
  logic              empty_q;
  logic              in_range_q;
  logic [ROW_AW-1:0] row_q;
  logic [ROW_BW-1:0] bit_q;

  // Result registers
  logic            granted_q;
  logic [ID_W-1:0] given_q;
  logic            released_q;

  // Accept-side signals
  logic [ID_W-1:0]   off;
  logic [ROW_AW-1:0] rd_row;

  // Update-side signals
  logic [ROW_W-1:0]  rdata;
  logic [ROW_W-1:0]  row_data;
  logic [ROW_W-1:0]  new_row;
  logic [ROW_BW-1:0] low_bit;
  logic              do_alloc;
  logic              do_release;
  logic              we;
  logic [ID_W-1:0]   alloc_id;

  // Offset of the released ID and the row to read
  assign off    = release_id_i - base_id_i;
  assign rd_row = (op_i == OP_RELEASE) ? ROW_AW'(off >> ROW_BW) : lowest_row(summary_q);

  // Latch the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= op_i;
      empty_q    <= (summary_q == '0);
      in_range_q <= (off < ID_W'(n_i));
      row_q      <= rd_row;
      bit_q      <= off[ROW_BW-1:0];
    end
  end

  lfida_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (row_q),
    .wdata_i (new_row),
    .re_i    (cmd_i.accept),
    .raddr_i (rd_row),
    .rdata_o (rdata)
  );

  // A row never written since init reads as its initial content
  assign row_data = row_valid_q[row_q] ? rdata : init_row(row_q, n_i);
  assign low_bit  = lowest_bit(row_data);

  assign do_alloc   = (op_q == OP_ALLOC) && !empty_q;
  assign do_release = (op_q == OP_RELEASE) && in_range_q && !row_data[bit_q];
  assign we         = cmd_i.commit && (do_alloc || do_release);

  // Clear the granted bit or set the released one
  always_comb begin
    new_row = row_data;
    if (op_q == OP_ALLOC) begin
      new_row[low_bit] = 1'b0;
    end else begin
      new_row[bit_q] = 1'b1;
    end
  end

  assign alloc_id = base_id_i + ((ID_W'(row_q) << ROW_BW) | ID_W'(low_bit));

  // Summary, valid bits and free counter
  always_comb begin
    summary_d    = summary_q;
    row_valid_d  = row_valid_q;
    free_total_d = free_total_q;
    if (cfg_init_i) begin
      summary_d    = init_summary(n_i);
      row_valid_d  = '0;
      free_total_d = n_i;
    end else if (we) begin
      summary_d[row_q]   = |new_row;
      row_valid_d[row_q] = 1'b1;
      free_total_d       = do_alloc ? free_total_q - 1'b1 : free_total_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summary_q    <= '0;
      row_valid_q  <= '0;
      free_total_q <= '0;
    end else begin
      summary_q    <= summary_d;
      row_valid_q  <= row_valid_d;
      free_total_q <= free_total_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      granted_q  <= do_alloc;
      given_q    <= do_alloc ? alloc_id : '0;
      released_q <= do_release;
    end
  end

  assign granted_o    = granted_q;
  assign given_id_o   = given_q;
  assign released_o   = released_q;
  assign free_count_o = free_total_q;

endmodule

// File: rtl/lfida_checker.sv
// ----------------------------------------------------------------------------
// lfida_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module lfida_checker
  import lfida_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             granted_o,
  input logic [ID_W-1:0]  given_id_o,
  input logic             released_o,
  input logic [CNT_W-1:0] free_count_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(given_id_o)
      && $stable(free_count_o))
    else $error("stalled result changed");

  // No input transfer right after an input transfer
  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken in back-to-back cycles");

  // A result never both grants and releases
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(granted_o && released_o))
    else $error("granted and released both set");

  // No grant, no ID
  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> given_id_o == '0)
    else $error("given_id nonzero without grant");

  // Free count stays within the pool
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_count_o <= CNT_MAX)
    else $error("free count above pool size");

endmodule

bind lowest_free_id_allocator_top lfida_checker u_lfida_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .granted_o    (granted_o),
  .given_id_o   (given_id_o),
  .released_o   (released_o),
  .free_count_o (free_count_o)
);

// File: tb/sv/tb_lowest_free_id_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_free_id_allocator_top
// Self-checking bench for the lowest-free ID allocator. A shadow pool predicts
// the response of every accepted request. Requests are sent in random bursts
// while the result side stalls on changing patterns. The pool is reprogrammed
// over the register port between phases: wrapped ranges, empty, single-ID,
// full and clipped pools.
// ----------------------------------------------------------------------------
module tb_lowest_free_id_allocator_top;
  import lfida_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] rel_id;
  } request_t;

  typedef struct packed {
    logic             granted;
    logic [ID_W-1:0]  given_id;
    logic             released;
    logic [CNT_W-1:0] free_count;
  } response_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic              op_i         = OP_ALLOC;
  logic [ID_W-1:0]   release_id_i = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic              granted_o;
  logic [ID_W-1:0]   given_id_o;
  logic              released_o;
  logic [CNT_W-1:0]  free_count_o;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [CFG_AW-1:0] paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;

  lowest_free_id_allocator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .release_id_i (release_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .granted_o    (granted_o),
    .given_id_o   (given_id_o),
    .released_o   (released_o),
    .free_count_o (free_count_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow pool: free bits, free count and programmed range
  logic [POOL_SIZE-1:0] pool_free;
  logic [CNT_W-1:0]     pool_free_cnt;
  logic [ID_W-1:0]      pool_base;
  logic [CNT_W-1:0]     pool_count;

  request_t  request_q[$];
  response_t response_q[$];
  int        errors = 0;

  function automatic int usable_ids();
    return (int'(pool_count) > POOL_SIZE) ? POOL_SIZE : int'(pool_count);
  endfunction

  // Mark every ID in range free
  function automatic void refill_pool();
    int n;
    n = usable_ids();
    pool_free = '0;
    for (int i = 0; i < n; i++) begin
      pool_free[i] = 1'b1;
    end
    pool_free_cnt = CNT_W'(n);
  endfunction

  // Grant the lowest free ID or return a released one; update the shadow pool
  function automatic response_t apply_request(request_t req);
    response_t       rsp;
    int              n;
    logic [ID_W-1:0] off;
    logic            found;
    rsp   = '0;
    n     = usable_ids();
    found = 1'b0;
    if (req.op == OP_ALLOC) begin
      for (int i = 0; i < n; i++) begin
        if (!found && pool_free[i]) begin
          found         = 1'b1;
          pool_free[i]  = 1'b0;
          pool_free_cnt = pool_free_cnt - 1'b1;
          rsp.granted   = 1'b1;
          rsp.given_id  = pool_base + ID_W'(i);
        end
      end
    end else begin
      off = req.rel_id - pool_base;
      if (off < ID_W'(n) && !pool_free[off]) begin
        pool_free[off] = 1'b1;
        pool_free_cnt  = pool_free_cnt + 1'b1;
        rsp.released   = 1'b1;
      end
    end
    rsp.free_count = pool_free_cnt;
    return rsp;
  endfunction

  task automatic check_field(string name, logic [ID_W-1:0] exp_v, logic [ID_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Request driver: bursts of random length separated by random gaps
  request_t cur_req    = '0;
  int       gap_left   = 0;
  int       burst_left = 8;

  always @(posedge clk_i) begin
    request_t nxt;
    logic     hold;
    logic     nxt_valid;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        response_q.push_back(apply_request(cur_req));
      end
      // hold the payload while stalled
      hold = in_valid_i && in_stall_o;
      if (!hold) begin
        nxt_valid = 1'b0;
        nxt       = cur_req;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          nxt       = request_q[0];
          request_q.delete(0);
          nxt_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(40, 120);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = $urandom_range(0, 8);
            end
          end
        end
        cur_req      = nxt;
        in_valid_i   <= nxt_valid;
        op_i         <= nxt.op;
        release_id_i <= nxt.rel_id;
      end
    end
  end

  // Result monitor and stall generator
  int stall_mode = 0;
  int mode_left  = 100;
  int stall_run  = 0;

  always @(posedge clk_i) begin
    response_t exp_rsp;
    logic      nxt_stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (response_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: granted=%0b given_id=%0h released=%0b free_count=%0d",
                   $time, granted_o, given_id_o, released_o, free_count_o);
        end else begin
          exp_rsp = response_q[0];
          response_q.delete(0);
          check_field("granted", ID_W'(exp_rsp.granted), ID_W'(granted_o));
          check_field("given_id", exp_rsp.given_id, given_id_o);
          check_field("released", ID_W'(exp_rsp.released), ID_W'(released_o));
          check_field("free_count", ID_W'(exp_rsp.free_count), ID_W'(free_count_o));
        end
      end
      // switch the stall pattern now and then
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(30, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: nxt_stall = 1'b0;
        1: nxt_stall = ($urandom_range(0, 2) == 0);
        2: begin
          if (stall_run > 0) begin
            stall_run--;
            nxt_stall = 1'b1;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_run = $urandom_range(1, 10);
            nxt_stall = 1'b1;
          end else begin
            nxt_stall = 1'b0;
          end
        end
        default: nxt_stall = ~out_stall_i;
      endcase
      out_stall_i <= nxt_stall;
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Register write: setup cycle, then access cycle; refill the shadow pool
  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BASE_ID) begin
      pool_base = data;
    end else begin
      pool_count = data[CNT_W-1:0];
    end
    refill_pool();
  endtask

  // Program base and count; unused upper bits of the count get random junk
  task automatic set_pool(logic [ID_W-1:0] base, logic [CNT_W-1:0] count);
    logic [31:0] junk;
    junk = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom();
    write_reg(REG_BASE_ID, base);
    write_reg(REG_ID_COUNT, {junk[31:CNT_W], count});
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || response_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void push_req(logic op, logic [ID_W-1:0] rel_id);
    request_t req;
    req.op     = op;
    req.rel_id = rel_id;
    request_q.push_back(req);
  endfunction

  // Random requests; releases mostly target IDs in range, some miss it
  function automatic void push_random(int items, int alloc_pct);
    request_t req;
    int       n;
    int       kind;
    n = usable_ids();
    repeat (items) begin
      req.op = ($urandom_range(1, 100) <= alloc_pct) ? OP_ALLOC : OP_RELEASE;
      kind   = $urandom_range(0, 9);
      if (kind <= 6 && n > 0) begin
        req.rel_id = pool_base + ID_W'($urandom_range(0, n - 1));
      end else if (kind == 7) begin
        req.rel_id = pool_base + ID_W'(n) + ID_W'($urandom_range(0, 3));
      end else if (kind == 8) begin
        req.rel_id = pool_base - 1 - ID_W'($urandom_range(0, 3));
      end else begin
        req.rel_id = $urandom();
      end
      request_q.push_back(req);
    end
  endfunction

  initial begin
    pool_base  = '0;
    pool_count = '0;
    refill_pool();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty pool after reset: refuse allocation, ignore releases
    @(negedge clk_i);
    push_req(OP_ALLOC, 32'h0);
    push_req(OP_RELEASE, 32'h0);
    push_req(OP_RELEASE, 32'hFFFF_FFFF);
    wait_idle();

    // range wrapping past 2^32: drain, refuse, release in and out of range
    set_pool(32'hFFFF_FFFC, 9'd6);
    repeat (7) push_req(OP_ALLOC, $urandom());
    push_req(OP_RELEASE, 32'h0000_0001);
    push_req(OP_RELEASE, 32'hFFFF_FFFD);
    push_req(OP_RELEASE, 32'hFFFF_FFFD);
    push_req(OP_RELEASE, 32'h0000_0002);
    push_req(OP_RELEASE, 32'hFFFF_FFFB);
    push_req(OP_ALLOC, 32'h0);
    push_req(OP_ALLOC, 32'hFFFF_FFFF);
    wait_idle();

    // oversized count clipped to the pool size
    set_pool(32'h0, 9'h1FF);
    repeat (3) push_req(OP_ALLOC, 32'h0);
    push_req(OP_RELEASE, 32'd255);
    push_req(OP_RELEASE, 32'd1);
    push_req(OP_RELEASE, 32'd256);
    push_req(OP_ALLOC, 32'h0);
    wait_idle();

    // random phases over several pool settings
    set_pool($urandom(), 9'd8);
    push_random(150, 50);
    wait_idle();
    set_pool(32'hFFFF_FFF8, 9'd16);
    push_random(150, 55);
    wait_idle();
    set_pool($urandom(), 9'd256);
    push_random(300, 90);
    wait_idle();
    // a base write alone refills the pool
    write_reg(REG_BASE_ID, 32'h0);
    @(negedge clk_i);
    push_random(80, 30);
    wait_idle();
    set_pool(32'h0, 9'd300);
    push_random(100, 40);
    wait_idle();
    set_pool($urandom(), 9'd1);
    push_random(100, 50);
    wait_idle();
    set_pool(32'hFFFF_FFFF, 9'd3);
    push_random(100, 50);
    wait_idle();
    set_pool($urandom(), 9'd0);
    push_random(40, 50);
    wait_idle();
    set_pool($urandom(), 9'd32);
    push_random(180, 60);
    wait_idle();
    set_pool($urandom(), CNT_W'($urandom_range(0, 511)));
    push_random(150, 50);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
